/* rtl/core/bss_pkg.sv */
// bss_pkg: shared types for the beep step sequencer.
// Holds the step and result word layouts and the sequencer state enum.
// No dependencies.
package bss_pkg;

	localparam int unsigned FREQ_W  = 16;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned COUNT_W = 4;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [FREQ_W-1:0] step_freq;
		logic [MS_W-1:0]   step_ms;
		logic              first_step;
		logic              last_step;
	} step_word_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  tone_freq;
		logic               playing;
		logic               step_dropped;
		logic [COUNT_W-1:0] queue_count;
	} result_word_t;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [MS_W-1:0]   ms;
	} queue_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} seq_state_t;

endpackage

/* rtl/core/bss_step_if.sv */
// bss_step_if / bss_result_if: valid/ready channels of the sequencer.
// Depends on bss_pkg for the word layouts.
interface bss_step_if;
	import bss_pkg::*;
	logic       valid;
	logic       ready;
	step_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bss_result_if;
	import bss_pkg::*;
	logic         valid;
	logic         ready;
	result_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/beep_step_sequencer_unit.sv */
// beep_step_sequencer_unit: tone step sequencer with a ring queue in a memory.
// Depends on bss_pkg and the channel interfaces in bss_step_if.sv.
//
// Usage: step_in carries either a 1 ms tick or a step entry (frequency,
// duration, first and last marks); every accepted word yields exactly one
// word on result_out with the tone now driven, the playing flag, the drop
// flag of that entry and the number of queued steps.
// The queue holds QUEUE_DEPTH-1 steps in a synchronous one-port-write,
// one-port-read memory whose read data is registered.
// Timing: a word that does not start a queued step is answered in the cycle
// after acceptance. A word that starts the head step (a last mark, or a tick
// that ends the current step, with steps waiting) goes through ST_READ and
// ST_LOAD: the head read is issued the cycle after the queue write, its data
// is loaded the cycle after that and the result is registered from it.
// Throughput: one word per cycle when no head step starts and the receiver
// takes each result; step_in is not ready while the head is read and loaded.
// Reset: indices, countdown and tone clear, queue contents stay undefined.
// A stalled receiver holds the result register; step_in stays ready in ST_IDLE
// while the result is taken in the same cycle.
module beep_step_sequencer_unit #(
	parameter int unsigned QUEUE_DEPTH = 12
) (
	input  logic clk,
	input  logic arst_n,
	bss_step_if.sink     step_in,
	bss_result_if.source result_out
);
	import bss_pkg::*;

	localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = (IW > COUNT_W) ? IW : COUNT_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
	localparam logic [IW:0]   DEPTH_W  = (IW+1)'(QUEUE_DEPTH);

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [COUNT_W-1:0] fill_count(input logic [IW-1:0] r,
	                                                   input logic [IW-1:0] w);
		logic [IW:0] diff;
		logic [CW-1:0] ext;
		diff = (w >= r) ? ({1'b0, w} - {1'b0, r}) : ({1'b0, w} + DEPTH_W - {1'b0, r});
		ext  = CW'(diff[IW-1:0]);
		return ext[COUNT_W-1:0];
	endfunction

	queue_entry_t mem [QUEUE_DEPTH];
	queue_entry_t rdata_q;

	seq_state_t        state_q, state_d;
	logic [IW-1:0]     rd_idx_q, wr_idx_q;
	logic [MS_W-1:0]   rem_q;
	logic              snd_q;
	logic [FREQ_W-1:0] tone_q;
	logic              dropped_q;
	logic              out_valid_q;
	result_word_t      out_q;

	logic              in_ready, mem_re, acc;
	logic [IW-1:0]     n_rd, n_wr, ld_rd, wr_sel;
	logic [MS_W-1:0]   n_rem;
	logic              n_snd, n_dropped, we, start, head;
	logic [FREQ_W-1:0] n_tone;

	assign acc = step_in.valid && in_ready;

	always_comb begin
		n_rd      = rd_idx_q;
		n_wr      = wr_idx_q;
		n_rem     = rem_q;
		n_snd     = snd_q;
		n_tone    = tone_q;
		n_dropped = 1'b0;
		we        = 1'b0;
		start     = 1'b0;
		head      = 1'b0;
		if (step_in.data.req_type == REQ_TICK) begin
			if (snd_q) begin
				if (rem_q > MS_W'(1)) begin
					n_rem = rem_q - 1'b1;
				end else begin
					n_rem  = '0;
					n_tone = '0;
					start  = 1'b1;
				end
			end
		end else begin
			if (step_in.data.first_step) begin
				n_tone = '0;
				n_rd   = '0;
				n_wr   = '0;
				n_snd  = 1'b0;
				n_rem  = '0;
			end
			if (next_slot(n_wr) == n_rd) begin
				n_dropped = 1'b1;
			end else begin
				we   = 1'b1;
				n_wr = next_slot(n_wr);
			end
			start = step_in.data.last_step;
		end
		if (start) begin
			if (n_rd == n_wr) begin
				n_snd  = 1'b0;
				n_tone = '0;
				n_rem  = '0;
			end else begin
				head = 1'b1;
			end
		end
	end

	assign ld_rd  = next_slot(rd_idx_q);
	assign wr_sel = step_in.data.first_step ? '0 : wr_idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc && head) state_d = ST_READ;
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mem_re   = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = !out_valid_q || result_out.ready;
			ST_READ: mem_re   = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && we) mem[wr_sel] <= '{freq: step_in.data.step_freq,
		                                ms: step_in.data.step_ms};
		if (mem_re) rdata_q <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			rem_q       <= '0;
			snd_q       <= 1'b0;
			tone_q      <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((acc && !head) || state_q == ST_LOAD) out_valid_q <= 1'b1;
			else if (result_out.ready) out_valid_q <= 1'b0;
			if (acc) begin
				rd_idx_q  <= n_rd;
				wr_idx_q  <= n_wr;
				rem_q     <= n_rem;
				snd_q     <= n_snd;
				tone_q    <= n_tone;
				dropped_q <= n_dropped;
			end
			if (state_q == ST_LOAD) begin
				rd_idx_q    <= ld_rd;
				tone_q      <= rdata_q.freq;
				rem_q       <= rdata_q.ms;
				snd_q       <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !head) begin
			out_q.tone_freq    <= n_tone;
			out_q.playing      <= n_snd || (n_rd != n_wr);
			out_q.step_dropped <= n_dropped;
			out_q.queue_count  <= fill_count(n_rd, n_wr);
		end else if (state_q == ST_LOAD) begin
			out_q.tone_freq    <= rdata_q.freq;
			out_q.playing      <= 1'b1;
			out_q.step_dropped <= dropped_q;
			out_q.queue_count  <= fill_count(ld_rd, wr_idx_q);
		end
	end

	assign step_in.ready    = in_ready;
	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_q;

endmodule

/* rtl/core/bss_checker.sv */
// bss_checker: port-level assertions for beep_step_sequencer_unit.
// Bound to the top level below; depends on no package.
module bss_checker #(
	parameter int unsigned QUEUE_DEPTH = 12
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] tone_freq,
	input logic        playing,
	input logic        step_dropped,
	input logic [3:0]  queue_count
);

	localparam logic [3:0] FULL_CNT = 4'(QUEUE_DEPTH - 1);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word withdrawn before taken");

	a_tone_playing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tone_freq != 16'd0) |-> playing)
		else $error("tone driven while not playing");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !playing |-> (queue_count == 4'd0) && (tone_freq == 16'd0))
		else $error("stopped with steps queued or tone on");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_dropped && (QUEUE_DEPTH <= 16) |->
		(queue_count == FULL_CNT) || (tone_freq != 16'd0) || playing)
		else $error("step dropped while queue not full");

endmodule

bind beep_step_sequencer_unit bss_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_bss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result_out.valid),
	.out_ready    (result_out.ready),
	.tone_freq    (result_out.data.tone_freq),
	.playing      (result_out.data.playing),
	.step_dropped (result_out.data.step_dropped),
	.queue_count  (result_out.data.queue_count)
);
